// ===== hw/rtl/mwpo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_pkg
// Shared codes and constants for the multi-waveform phase oscillator.
// ----------------------------------------------------------------------------
package mwpo_pkg;

	typedef logic [1:0] wave_t;

	localparam wave_t WAVE_SINE     = 2'd0;
	localparam wave_t WAVE_TRIANGLE = 2'd1;
	localparam wave_t WAVE_SAWTOOTH = 2'd2;
	localparam wave_t WAVE_SQUARE   = 2'd3;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	localparam longint unsigned Q30_ONE    = 64'd1 << 30;
	localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
	localparam logic [31:0]     HALF_CYCLE = 32'h8000_0000;

	typedef struct packed {
		logic  kind;
		wave_t wave;
	} item_ctl_t;

endpackage

// ===== hw/rtl/mwpo_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_sine_rom
// Quarter-wave sine magnitude table with registered read, addressed by phase.
// ----------------------------------------------------------------------------
module mwpo_sine_rom #(
	parameter int PHASE_BITS     = 24,
	parameter int SINE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [PHASE_BITS-1:0]  phase,
	output logic [SAMPLE_BITS-2:0] mag
);

	localparam int DEPTH = 1 << SINE_ADDR_BITS;
	localparam int MAG_W = SAMPLE_BITS - 1;

	typedef logic [MAG_W-1:0] rom_t [DEPTH];

	function automatic rom_t build_rom();
		rom_t            r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned m;
		for (int i = 0; i < DEPTH; i++) begin
			x  = (64'(2 * i + 1) * mwpo_pkg::HALFPI_Q30) >> (SINE_ADDR_BITS + 1);
			x2 = (x * x) >> 30;
			t  = mwpo_pkg::Q30_ONE;
			t  = mwpo_pkg::Q30_ONE - (((x2 * t) >> 30) / 156);
			t  = mwpo_pkg::Q30_ONE - (((x2 * t) >> 30) / 110);
			t  = mwpo_pkg::Q30_ONE - (((x2 * t) >> 30) / 72);
			t  = mwpo_pkg::Q30_ONE - (((x2 * t) >> 30) / 42);
			t  = mwpo_pkg::Q30_ONE - (((x2 * t) >> 30) / 20);
			t  = mwpo_pkg::Q30_ONE - (((x2 * t) >> 30) / 6);
			s  = (x * t) >> 30;
			m  = (s + (64'd1 << (31 - SAMPLE_BITS))) >> (32 - SAMPLE_BITS);
			r[i] = MAG_W'(m);
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic [31:0]               p32;
	logic [SINE_ADDR_BITS-1:0] addr;

	always_comb begin
		p32  = 32'(phase) << (32 - PHASE_BITS);
		addr = p32[29 -: SINE_ADDR_BITS];
		if (p32[30]) begin
			addr = ~addr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= ROM[addr];
		end
	end

endmodule

// ===== hw/rtl/mwpo_shaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwpo_shaper
// Triangle, sawtooth and square samples computed directly from the phase.
// ----------------------------------------------------------------------------
module mwpo_shaper #(
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic [PHASE_BITS-1:0]         phase,
	output logic signed [SAMPLE_BITS-1:0] tri_sample,
	output logic signed [SAMPLE_BITS-1:0] saw_sample,
	output logic signed [SAMPLE_BITS-1:0] square_sample
);

	logic [31:0]            p32;
	logic [31:0]            span;
	logic [31:0]            near;
	logic [32:0]            tri_sum;
	logic [32:0]            saw_sum;
	logic [SAMPLE_BITS-1:0] quarter;

	always_comb begin
		p32     = 32'(phase) << (32 - PHASE_BITS);
		span    = (p32 >= mwpo_pkg::HALF_CYCLE) ? (p32 - mwpo_pkg::HALF_CYCLE)
			: (mwpo_pkg::HALF_CYCLE - p32);
		near    = mwpo_pkg::HALF_CYCLE - span;
		tri_sum = ({1'b0, near} + (33'd1 << (33 - SAMPLE_BITS))) >> (34 - SAMPLE_BITS);
		saw_sum = ({1'b0, p32} + (33'd1 << (33 - SAMPLE_BITS))) >> (34 - SAMPLE_BITS);
		quarter = SAMPLE_BITS'(1) << (SAMPLE_BITS - 3);

		tri_sample    = -SAMPLE_BITS'(tri_sum);
		saw_sample    = SAMPLE_BITS'(saw_sum) - quarter;
		square_sample = (p32 > mwpo_pkg::HALF_CYCLE) ? -quarter : quarter;
	end

endmodule

// ===== hw/rtl/multi_waveform_phase_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator
// Phase-accumulator oscillator giving sine, triangle, sawtooth or square
// samples in signed fixed point, with phase load.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                Word
//  s_axis    in         s_axis_tvalid/tready     tuser: kind, waveform; tdata: phase
//  m_axis    out        m_axis_tvalid/tready     tdata: sample, phase_out
//  cfg       in         cfg_valid/cfg_ready      cfg_data: phase_step
//
// One word is accepted per cycle unless the output stalls. The phase sum is
// formed at input into the first stage; the table read address, the table
// read and the direct waveforms are formed from it into the second stage; the
// final select fills the output register. When the output word is not taken
// the whole pipeline holds. Reset clears the phase, the step and all valid
// bits; the sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator #(
	parameter int PHASE_BITS     = 24,
	parameter int SINE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// [PHASE_BITS-1:0] phase_value, zero fill above.
	input  logic [((PHASE_BITS + 7) / 8) * 8 - 1:0]       s_axis_tdata,
	// [0] kind, [2:1] waveform.
	input  logic [2:0]                                    s_axis_tuser,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// [SAMPLE_BITS-1:0] sample, then phase_out, zero fill above.
	output logic [((SAMPLE_BITS + PHASE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [PHASE_BITS-1:0]                         cfg_data
);

	localparam int OUT_W = ((SAMPLE_BITS + PHASE_BITS + 7) / 8) * 8;

	logic                          adv;
	logic                          accept;
	mwpo_pkg::item_ctl_t           in_ctl;
	logic [PHASE_BITS-1:0]         phase_next;

	logic [PHASE_BITS-1:0]         step_q;
	logic [PHASE_BITS-1:0]         phase_acc_q;

	logic                          valid_s1;
	mwpo_pkg::item_ctl_t           ctl_s1;
	logic [PHASE_BITS-1:0]         phase_s1;

	logic                          valid_s2;
	mwpo_pkg::item_ctl_t           ctl_s2;
	logic [PHASE_BITS-1:0]         phase_s2;
	logic                          neg_s2;
	logic [SAMPLE_BITS-2:0]        mag_s2;
	logic signed [SAMPLE_BITS-1:0] tri_s2;
	logic signed [SAMPLE_BITS-1:0] saw_s2;
	logic signed [SAMPLE_BITS-1:0] square_s2;

	logic signed [SAMPLE_BITS-1:0] tri_c;
	logic signed [SAMPLE_BITS-1:0] saw_c;
	logic signed [SAMPLE_BITS-1:0] square_c;
	logic signed [SAMPLE_BITS-1:0] sine_c;
	logic signed [SAMPLE_BITS-1:0] sample_c;

	logic                          out_valid_q;
	logic                          out_load_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [PHASE_BITS-1:0]         phase_out_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign cfg_ready     = 1'b1;
	assign in_ctl        = '{kind: s_axis_tuser[0], wave: s_axis_tuser[2:1]};
	assign phase_next    = (in_ctl.kind == mwpo_pkg::KIND_LOAD) ? s_axis_tdata[PHASE_BITS-1:0]
		: phase_acc_q + step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			phase_acc_q <= '0;
		end else begin
			if (cfg_valid) begin
				step_q <= cfg_data;
			end
			if (accept) begin
				phase_acc_q <= phase_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	mwpo_sine_rom #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_sine_rom (
		.clk   (clk),
		.en    (adv),
		.phase (phase_s1),
		.mag   (mag_s2)
	);

	mwpo_shaper #(
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_shaper (
		.phase         (phase_s1),
		.tri_sample    (tri_c),
		.saw_sample    (saw_c),
		.square_sample (square_c)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1      <= in_ctl;
			phase_s1    <= phase_next;
			ctl_s2      <= ctl_s1;
			phase_s2    <= phase_s1;
			neg_s2      <= phase_s1[PHASE_BITS-1];
			tri_s2      <= tri_c;
			saw_s2      <= saw_c;
			square_s2   <= square_c;
			out_load_q  <= (ctl_s2.kind == mwpo_pkg::KIND_LOAD);
			sample_q    <= sample_c;
			phase_out_q <= phase_s2;
		end
	end

	always_comb begin
		sine_c = neg_s2 ? -$signed({1'b0, mag_s2}) : $signed({1'b0, mag_s2});
		case (ctl_s2.wave)
			mwpo_pkg::WAVE_SINE:     sample_c = sine_c;
			mwpo_pkg::WAVE_TRIANGLE: sample_c = tri_s2;
			mwpo_pkg::WAVE_SAWTOOTH: sample_c = saw_s2;
			default:                 sample_c = square_s2;
		endcase
		if (ctl_s2.kind == mwpo_pkg::KIND_LOAD) begin
			sample_c = '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({phase_out_q, sample_q});

`ifndef NO_ASSERTIONS
	a_load_sets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tuser[0] == mwpo_pkg::KIND_LOAD
		|=> phase_acc_q == $past(s_axis_tdata[PHASE_BITS-1:0]))
		else $error("Load word did not set the phase accumulator.");

	a_tick_adds_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tuser[0] == mwpo_pkg::KIND_TICK
		|=> phase_acc_q == PHASE_BITS'($past(phase_acc_q) + $past(step_q)))
		else $error("Tick word did not advance the phase by the step.");

	a_stall_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_acc_q))
		else $error("Phase accumulator moved during an output stall.");

	a_load_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_load_q |-> sample_q == '0)
		else $error("Load result carries a nonzero sample.");
`endif

endmodule

// ===== sim/tb_multi_waveform_phase_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_waveform_phase_oscillator
// Self-checking bench for the phase oscillator. A directed table covers the
// reset state, phase extremes, quadrant and half-cycle boundaries, exact wrap
// and every waveform. It is followed by randomized runs of ticks and loads
// under several step settings, with random gaps and output stalls. Each
// output word is compared field by field against its row's wanted values or
// an in-bench model of the accumulator and the four waveform generators.
// ----------------------------------------------------------------------------
module tb_multi_waveform_phase_oscillator;

	localparam int PHASE_BITS     = 24;
	localparam int SINE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS    = 16;
	localparam int S_BYTES_W      = ((PHASE_BITS + 7) / 8) * 8;
	localparam int M_BYTES_W      = ((SAMPLE_BITS + PHASE_BITS + 7) / 8) * 8;
	localparam int DIR_ROWS       = 25;
	localparam int RUN_PHASES     = 8;
	localparam int RUN_WORDS      = 150;

	localparam logic [SAMPLE_BITS-1:0] QUARTER_POS = SAMPLE_BITS'(1) << (SAMPLE_BITS - 3);
	localparam logic [SAMPLE_BITS-1:0] QUARTER_NEG = -QUARTER_POS;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_ZERO = '0;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [PHASE_BITS-1:0]  phase;
	} osc_result_t;

	typedef struct packed {
		logic                   set_step;
		logic [PHASE_BITS-1:0]  step;
		logic                   kind;
		mwpo_pkg::wave_t        wave;
		logic [PHASE_BITS-1:0]  phase;
		logic                   typed;
		logic [SAMPLE_BITS-1:0] want_sample;
		logic [PHASE_BITS-1:0]  want_phase;
	} osc_row_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_BYTES_W-1:0]  s_axis_tdata  = '0;
	logic [2:0]            s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	logic [M_BYTES_W-1:0]  m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [PHASE_BITS-1:0] cfg_data      = '0;

	logic [PHASE_BITS-1:0] osc_phase = '0;
	logic [PHASE_BITS-1:0] osc_step  = '0;
	osc_result_t           pending_results [$];
	int                    mismatches = 0;
	bit                    gaps_on    = 1'b1;

	osc_row_t dir_table [DIR_ROWS] = '{
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SQUARE, 24'h000000,
			1'b1, QUARTER_POS, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SAWTOOTH, 24'h000000,
			1'b1, QUARTER_NEG, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_TRIANGLE, 24'h000000,
			1'b1, SAMPLE_ZERO, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SINE, 24'hFFFFFF,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_LOAD, mwpo_pkg::WAVE_SINE, 24'hFFFFFF,
			1'b1, SAMPLE_ZERO, 24'hFFFFFF},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SAWTOOTH, 24'h000000,
			1'b1, QUARTER_POS, 24'hFFFFFF},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_TRIANGLE, 24'h000000,
			1'b1, SAMPLE_ZERO, 24'hFFFFFF},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SINE, 24'h000000,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_LOAD, mwpo_pkg::WAVE_TRIANGLE, 24'h800000,
			1'b1, SAMPLE_ZERO, 24'h800000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SQUARE, 24'h000000,
			1'b1, QUARTER_POS, 24'h800000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_TRIANGLE, 24'h000000,
			1'b1, QUARTER_NEG, 24'h800000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SAWTOOTH, 24'h000000,
			1'b1, SAMPLE_ZERO, 24'h800000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SINE, 24'h000000,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_LOAD, mwpo_pkg::WAVE_SQUARE, 24'h800001,
			1'b1, SAMPLE_ZERO, 24'h800001},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SQUARE, 24'h000000,
			1'b1, QUARTER_NEG, 24'h800001},
		'{1'b1, 24'hFFFFFF, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SINE, 24'h000000,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b1, 24'h800000, mwpo_pkg::KIND_LOAD, mwpo_pkg::WAVE_SAWTOOTH, 24'h800000,
			1'b1, SAMPLE_ZERO, 24'h800000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SQUARE, 24'h000000,
			1'b1, QUARTER_POS, 24'h000000},
		'{1'b1, 24'h000001, mwpo_pkg::KIND_LOAD, mwpo_pkg::WAVE_SINE, 24'h3FFFFF,
			1'b1, SAMPLE_ZERO, 24'h3FFFFF},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SINE, 24'h000000,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_TRIANGLE, 24'h000000,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_LOAD, mwpo_pkg::WAVE_TRIANGLE, 24'hBFFFFF,
			1'b1, SAMPLE_ZERO, 24'hBFFFFF},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SINE, 24'h000000,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b0, 24'h000000, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SAWTOOTH, 24'h000000,
			1'b0, SAMPLE_ZERO, 24'h000000},
		'{1'b1, 24'h7FFFFF, mwpo_pkg::KIND_TICK, mwpo_pkg::WAVE_SINE, 24'hFFFFFF,
			1'b0, SAMPLE_ZERO, 24'h000000}
	};

	multi_waveform_phase_oscillator #(
		.PHASE_BITS    (PHASE_BITS),
		.SINE_ADDR_BITS(SINE_ADDR_BITS),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic osc_result_t advance_oscillator(input logic kind,
			input mwpo_pkg::wave_t wave, input logic [PHASE_BITS-1:0] load_phase);
		logic [31:0]            p32;
		logic [1:0]             quad;
		longint unsigned        idx, x, x2, t, s, mag, d;
		logic [SAMPLE_BITS-1:0] smp;
		int                     n;
		smp = '0;
		if (kind == mwpo_pkg::KIND_LOAD) begin
			osc_phase = load_phase;
		end else begin
			osc_phase = osc_phase + osc_step;
			p32 = {osc_phase, {(32 - PHASE_BITS){1'b0}}};
			case (wave)
				mwpo_pkg::WAVE_SINE: begin
					quad = p32[31:30];
					idx = (64'(p32) >> (30 - SINE_ADDR_BITS)) &
						((64'd1 << SINE_ADDR_BITS) - 64'd1);
					if (quad[0])
						idx = ((64'd1 << SINE_ADDR_BITS) - 64'd1) - idx;
					x = ((64'd2 * idx + 64'd1) * mwpo_pkg::HALFPI_Q30) >>
						(SINE_ADDR_BITS + 1);
					x2 = (x * x) >> 30;
					t = mwpo_pkg::Q30_ONE;
					for (n = 6; n >= 1; n--)
						t = mwpo_pkg::Q30_ONE -
							(((x2 * t) >> 30) / longint'((2 * n) * (2 * n + 1)));
					s = (x * t) >> 30;
					mag = (s + (64'd1 << (31 - SAMPLE_BITS))) >> (32 - SAMPLE_BITS);
					smp = quad[1] ? -mag[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];
				end
				mwpo_pkg::WAVE_TRIANGLE: begin
					d = (p32 >= mwpo_pkg::HALF_CYCLE) ? 64'(p32 - mwpo_pkg::HALF_CYCLE)
						: 64'(mwpo_pkg::HALF_CYCLE - p32);
					mag = ((64'(mwpo_pkg::HALF_CYCLE) - d) + (64'd1 << (33 - SAMPLE_BITS))) >>
						(34 - SAMPLE_BITS);
					smp = -mag[SAMPLE_BITS-1:0];
				end
				mwpo_pkg::WAVE_SAWTOOTH: begin
					mag = (64'(p32) + (64'd1 << (33 - SAMPLE_BITS))) >> (34 - SAMPLE_BITS);
					smp = mag[SAMPLE_BITS-1:0] - QUARTER_POS;
				end
				default: begin
					smp = (p32 > mwpo_pkg::HALF_CYCLE) ? QUARTER_NEG : QUARTER_POS;
				end
			endcase
		end
		return {smp, osc_phase};
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ERROR %s", $time, what);
		mismatches++;
	endtask

	task automatic send_word(input logic kind, input mwpo_pkg::wave_t wave,
			input logic [PHASE_BITS-1:0] phase, input logic typed, input osc_result_t want);
		osc_result_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {wave, kind};
		s_axis_tdata  <= S_BYTES_W'(phase);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = advance_oscillator(kind, wave, phase);
		pending_results.push_back(typed ? want : predicted);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic write_step(input logic [PHASE_BITS-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		osc_step = value;
	endtask

	always @(posedge clk) begin
		osc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected word %h", m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.sample)
					report_mismatch($sformatf("sample got %h want %h",
						m_axis_tdata[SAMPLE_BITS-1:0], want.sample));
				if (m_axis_tdata[SAMPLE_BITS +: PHASE_BITS] !== want.phase)
					report_mismatch($sformatf("phase_out got %h want %h",
						m_axis_tdata[SAMPLE_BITS +: PHASE_BITS], want.phase));
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4))
					@(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("multi_waveform_phase_oscillator verification failed");
		$finish;
	end

	initial begin
		logic                  kind;
		mwpo_pkg::wave_t       wave;
		logic [PHASE_BITS-1:0] phase;
		logic [PHASE_BITS-1:0] step;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[r]) begin
			if (dir_table[r].set_step)
				write_step(dir_table[r].step);
			send_word(dir_table[r].kind, dir_table[r].wave, dir_table[r].phase,
				dir_table[r].typed, {dir_table[r].want_sample, dir_table[r].want_phase});
		end

		for (int ph = 0; ph < RUN_PHASES; ph++) begin
			case (ph)
				0: step = '0;
				1: step = 24'h000001;
				2: step = 24'h800000;
				3: step = 24'hFFFFFF;
				4: step = PHASE_BITS'($urandom_range(1, 1023));
				6: step = PHASE_BITS'($urandom_range(0, 24'h800000));
				default: step = PHASE_BITS'($urandom());
			endcase
			write_step(step);
			gaps_on = (ph < RUN_PHASES - 2) && (ph % 3 != 2);
			for (int w = 0; w < RUN_WORDS; w++) begin
				kind = ($urandom_range(0, 9) == 0) ? mwpo_pkg::KIND_LOAD : mwpo_pkg::KIND_TICK;
				wave = mwpo_pkg::wave_t'($urandom_range(0, 3));
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 5))
						0: phase = 24'h000000;
						1: phase = 24'hFFFFFF;
						2: phase = 24'h800000;
						3: phase = 24'h7FFFFF;
						4: phase = 24'h400000;
						default: phase = 24'hC00000;
					endcase
				end else begin
					phase = PHASE_BITS'($urandom());
				end
				send_word(kind, wave, phase, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (mismatches == 0) begin
			$display("multi_waveform_phase_oscillator verification clean");
		end else begin
			$display("multi_waveform_phase_oscillator verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mwpo_pkg.sv
hw/rtl/mwpo_sine_rom.sv
hw/rtl/mwpo_shaper.sv
hw/rtl/multi_waveform_phase_oscillator.sv
sim/tb_multi_waveform_phase_oscillator.sv
